@@ sv/fuse_fault_retry_controller_assert.svh @@
// assertion macros for the retry controller checker
`ifndef FUSE_FAULT_RETRY_CONTROLLER_ASSERT_SVH
`define FUSE_FAULT_RETRY_CONTROLLER_ASSERT_SVH

// same-cycle implication, off during reset
`define FFRC_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("retry controller assertion failed");

// next-cycle implication, off during reset
`define FFRC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("retry controller assertion failed");

// next-cycle implication, also checked across reset
`define FFRC_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
    label: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("retry controller assertion failed");

`endif

@@ sv/ffrc_pkg.sv @@
package ffrc_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_FAULT  = 2'd1,
        OP_ENABLE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_WINDOW_MS       = 2'd0,
        CFG_RETRY_LIMIT     = 2'd1,
        CFG_RESTART_WAIT_MS = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_idx;

    localparam logic [31:0] WINDOW_MS_RST       = 32'd10000;
    localparam logic [7:0]  RETRY_LIMIT_RST     = 8'd3;
    localparam logic [31:0] RESTART_WAIT_MS_RST = 32'd1000;
    localparam logic [7:0]  RETRY_MAX           = 8'hff;

    typedef struct packed {
        logic [31:0] window_ms;
        logic [7:0]  retry_limit;
        logic [31:0] restart_wait_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [31:0] window_start_ms;
        logic        window_open;
        logic [7:0]  retries_held;
        logic        critical_latched;
        logic        enable_level;
        logic [31:0] wait_remaining;
        logic        wait_active;
    } t_state;

endpackage

@@ sv/ffrc_step.sv @@
module ffrc_step (
    input  ffrc_pkg::t_op    i_op,
    input  logic             i_enable_value,
    input  ffrc_pkg::t_cfg   i_cfg,
    input  ffrc_pkg::t_state i_state,
    output ffrc_pkg::t_state o_state,
    output logic             o_fault_result
);

    logic [31:0] elapsed;
    logic        new_window;
    logic [7:0]  base_count;
    logic [7:0]  inc_count;

    assign elapsed    = i_state.now_ms - i_state.window_start_ms;
    assign new_window = !i_state.window_open || (elapsed > i_cfg.window_ms);
    assign base_count = new_window ? 8'd0 : i_state.retries_held;
    assign inc_count  = (base_count != ffrc_pkg::RETRY_MAX) ? 8'(base_count + 8'd1)
                                                            : base_count;

    always_comb begin
        o_state        = i_state;
        o_fault_result = 1'b0;
        unique case (i_op)
            ffrc_pkg::OP_TICK: begin
                o_state.now_ms = 32'(i_state.now_ms + 32'd1);
                if (i_state.wait_active) begin
                    if (i_state.wait_remaining <= 32'd1) begin
                        o_state.wait_remaining = 32'd0;
                        o_state.wait_active    = 1'b0;
                        o_state.enable_level   = 1'b1;
                    end else begin
                        o_state.wait_remaining = 32'(i_state.wait_remaining - 32'd1);
                    end
                end
            end
            ffrc_pkg::OP_FAULT: begin
                o_state.enable_level = 1'b0;
                o_state.retries_held = inc_count;
                if (new_window) begin
                    o_state.window_open     = 1'b1;
                    o_state.window_start_ms = i_state.now_ms;
                end
                if (inc_count > i_cfg.retry_limit) begin
                    o_state.critical_latched = 1'b1;
                    o_state.wait_active      = 1'b0;
                    o_state.wait_remaining   = 32'd0;
                    o_fault_result           = 1'b1;
                end else begin
                    o_state.wait_remaining = i_cfg.restart_wait_ms;
                    o_state.wait_active    = 1'b1;
                end
            end
            ffrc_pkg::OP_ENABLE: begin
                o_state.enable_level = i_enable_value;
            end
            ffrc_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

@@ sv/fuse_fault_retry_controller.sv @@
// Auto-retry (hiccup) controller for a load switch. Each input transfer is a
// millisecond tick, a fault report or an enable write, and each one returns
// exactly one result with the enable level, the latched critical fault, the
// retry count of the current window, the restart-wait flag and, for a fault
// report, whether it tripped the critical fault. The block takes one item per
// clock while results are taken: the item lands in an input register, the
// whole state update is one combinational pass from there into the result
// register, and a new item can follow every cycle. A full result register
// that is not taken holds the input stage, which then drops ready.
// Configuration writes are always accepted and should be made while no item
// is in flight; the critical fault clears only on reset.
module fuse_fault_retry_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic        i_enable_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_enable_out,
    output logic        o_critical_fault,
    output logic [7:0]  o_retry_count,
    output logic        o_restart_pending,
    output logic        o_fault_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    ffrc_pkg::t_cfg   r_cfg;
    ffrc_pkg::t_state r_state;
    ffrc_pkg::t_state n_state;
    logic             r_in_valid;
    logic [1:0]       r_op;
    logic             r_enable_value;
    logic             r_out_valid;
    logic             r_fault_result;
    logic             n_fault_result;
    logic             advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms       <= ffrc_pkg::WINDOW_MS_RST;
            r_cfg.retry_limit     <= ffrc_pkg::RETRY_LIMIT_RST;
            r_cfg.restart_wait_ms <= ffrc_pkg::RESTART_WAIT_MS_RST;
        end else if (i_cfg_valid) begin
            unique case (ffrc_pkg::t_cfg_idx'(i_cfg_index))
                ffrc_pkg::CFG_WINDOW_MS:       r_cfg.window_ms       <= i_cfg_data;
                ffrc_pkg::CFG_RETRY_LIMIT:     r_cfg.retry_limit     <= i_cfg_data[7:0];
                ffrc_pkg::CFG_RESTART_WAIT_MS: r_cfg.restart_wait_ms <= i_cfg_data;
                ffrc_pkg::CFG_UNUSED: begin
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op           <= i_op;
            r_enable_value <= i_enable_value;
        end
    end

    ffrc_step u_step (
        .i_op           (ffrc_pkg::t_op'(r_op)),
        .i_enable_value (r_enable_value),
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_fault_result (n_fault_result)
    );

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fault_result <= n_fault_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_enable_out      = r_state.enable_level;
    assign o_critical_fault  = r_state.critical_latched;
    assign o_retry_count     = r_state.retries_held;
    assign o_restart_pending = r_state.wait_active;
    assign o_fault_result    = r_fault_result;

endmodule

@@ sv/ffrc_checker.sv @@
`include "fuse_fault_retry_controller_assert.svh"

module ffrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_enable_out,
    input logic        o_critical_fault,
    input logic [7:0]  o_retry_count,
    input logic        o_restart_pending,
    input logic        o_fault_result
);

    logic [11:0] out_bus;

    assign out_bus = {o_enable_out, o_critical_fault, o_retry_count,
                      o_restart_pending, o_fault_result};

    // no result right after reset
    `FFRC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

    // stalled result holds
    `FFRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(out_bus))

    // a tripping fault latches critical, switches off and cancels the wait
    `FFRC_ASSERT_IMPLY(a_trip_state, i_clk, i_rst_n, o_out_valid && o_fault_result,
        o_critical_fault && !o_enable_out && !o_restart_pending && (o_retry_count != 8'd0))

    // an empty result register never blocks input
    `FFRC_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule

bind fuse_fault_retry_controller ffrc_checker u_ffrc_checker (.*);
